// ----- src/trapezoid_wave_source_core_defines.svh -----
// Assertion macros shared by the trapezoid wave source modules.
// Each macro expects clk and rst in the scope where it is used.
`ifndef TRAPEZOID_WAVE_SOURCE_CORE_DEFINES_SVH
`define TRAPEZOID_WAVE_SOURCE_CORE_DEFINES_SVH

`define TWS_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tws check failed");

`define TWS_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tws check failed");

`endif

// ----- src/tws_pkg.sv -----
package tws_pkg;

  localparam int PHASE_W        = 32;
  localparam int LEVEL_W        = 16;
  localparam int DERIV_W        = 32;
  localparam int DATA_W         = 32;
  localparam int ADDR_W         = 5;
  localparam int QUOT_W         = 16;
  localparam int PROD_W         = QUOT_W + PHASE_W;
  localparam int PHASE_BITS_DEF = 32;
  localparam int LEVEL_BITS_DEF = 16;

  localparam logic signed [LEVEL_W-1:0] LEVEL_HIGH_RST   = 16'sd1000;
  localparam logic signed [LEVEL_W-1:0] LEVEL_LOW_RST    = 16'sd0;
  localparam logic [PHASE_W-1:0]        PHASE_OFFSET_RST = 32'd0;
  localparam logic [PHASE_W-1:0]        LOW_END_RST      = 32'd2147483648;
  localparam logic [PHASE_W-1:0]        SLEW_LEN_RST     = 32'd42949673;
  localparam logic signed [DERIV_W-1:0] SLOPE_RST        = 32'sd100000;

  localparam logic signed [DERIV_W-1:0] DERIV_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DERIV_W-1:0] SLOPE_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    RGN_FALL = 2'd0,
    RGN_LOW  = 2'd1,
    RGN_RISE = 2'd2,
    RGN_HIGH = 2'd3
  } region_t;

  typedef enum logic [2:0] {
    IDX_LEVEL_HIGH   = 3'd0,
    IDX_LEVEL_LOW    = 3'd1,
    IDX_PHASE_OFFSET = 3'd2,
    IDX_LOW_END      = 3'd3,
    IDX_SLEW_LEN     = 3'd4,
    IDX_SLOPE        = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level_high;
    logic signed [LEVEL_W-1:0] level_low;
    logic [PHASE_W-1:0]        phase_offset;
    logic [PHASE_W-1:0]        low_end;
    logic [PHASE_W-1:0]        slew_len;
    logic signed [DERIV_W-1:0] slope;
  } cfg_t;

  typedef struct packed {
    region_t                   region;
    logic signed [LEVEL_W-1:0] base;
    logic                      neg;
    logic signed [DERIV_W-1:0] deriv;
  } side_t;

endpackage

// ----- src/tws_stream_if.sv -----
interface tws_phase_if;
  logic                         valid;
  logic                         ready;
  logic [tws_pkg::PHASE_W-1:0] time_phase;

  modport source (output valid, output time_phase, input ready);
  modport sink (input valid, input time_phase, output ready);
endinterface

interface tws_wave_if #(
  parameter int LEVEL_BITS = tws_pkg::LEVEL_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic signed [LEVEL_BITS-1:0]        voltage;
  logic signed [tws_pkg::DERIV_W-1:0] derivative;
  logic [1:0]                          region;

  modport source (output valid, output voltage, output derivative, output region, input ready);
  modport sink (input valid, input voltage, input derivative, input region, output ready);
endinterface

// ----- src/trapezoid_wave_source_core.sv -----
// Throughput: one item per cycle while the skid entry is empty; phase add, classify, multiply,
// a 16-stage restoring divider (one quotient bit per stage) and an output register.
// On a wave_stream stall one more result lands in a skid entry, then input stalls.
// Reset (rst, synchronous): empties the pipeline and restores register defaults.
`include "trapezoid_wave_source_core_defines.svh"

module trapezoid_wave_source_core #(
  parameter int PHASE_BITS = tws_pkg::PHASE_BITS_DEF,
  parameter int LEVEL_BITS = tws_pkg::LEVEL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  tws_phase_if.sink                   phase_stream,
  tws_wave_if.source                  wave_stream,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tws_pkg::ADDR_W-1:0] paddr,
  input  logic [tws_pkg::DATA_W-1:0] pwdata,
  output logic [tws_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  tws_pkg::cfg_t               cfg;
  logic                        en;
  logic                        front_valid;
  logic [tws_pkg::PROD_W-1:0] front_prod;
  tws_pkg::side_t              front_side;
  logic                        div_valid;
  logic [tws_pkg::QUOT_W-1:0] div_quot;
  tws_pkg::side_t              div_side;
  tws_pkg::region_t            out_region;

  tws_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign phase_stream.ready = en;

  tws_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (phase_stream.valid),
    .time_phase (phase_stream.time_phase),
    .cfg        (cfg),
    .out_valid  (front_valid),
    .out_prod   (front_prod),
    .out_side   (front_side)
  );

  tws_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_prod   (front_prod),
    .in_side   (front_side),
    .slew_len  (cfg.slew_len),
    .out_valid (div_valid),
    .out_quot  (div_quot),
    .out_side  (div_side)
  );

  tws_out #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (div_valid),
    .in_quot    (div_quot),
    .in_side    (div_side),
    .en         (en),
    .out_valid  (wave_stream.valid),
    .out_ready  (wave_stream.ready),
    .voltage    (wave_stream.voltage),
    .derivative (wave_stream.derivative),
    .region     (out_region)
  );

  assign wave_stream.region = out_region;

  `TWS_CHECK_NOW(a_flat_zero_slope, wave_stream.valid && (out_region == tws_pkg::RGN_LOW || out_region == tws_pkg::RGN_HIGH), wave_stream.derivative == '0)

endmodule

// ----- src/tws_regs.sv -----
module tws_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tws_pkg::ADDR_W-1:0] paddr,
  input  logic [tws_pkg::DATA_W-1:0] pwdata,
  output logic [tws_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output tws_pkg::cfg_t               cfg
);

  tws_pkg::cfg_t     regs;
  tws_pkg::reg_idx_t idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx    = tws_pkg::reg_idx_t'(paddr[tws_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.level_high   <= tws_pkg::LEVEL_HIGH_RST;
      regs.level_low    <= tws_pkg::LEVEL_LOW_RST;
      regs.phase_offset <= tws_pkg::PHASE_OFFSET_RST;
      regs.low_end      <= tws_pkg::LOW_END_RST;
      regs.slew_len     <= tws_pkg::SLEW_LEN_RST;
      regs.slope        <= tws_pkg::SLOPE_RST;
    end else if (wr) begin
      case (idx)
        tws_pkg::IDX_LEVEL_HIGH:   regs.level_high   <= pwdata[tws_pkg::LEVEL_W-1:0];
        tws_pkg::IDX_LEVEL_LOW:    regs.level_low    <= pwdata[tws_pkg::LEVEL_W-1:0];
        tws_pkg::IDX_PHASE_OFFSET: regs.phase_offset <= pwdata;
        tws_pkg::IDX_LOW_END:      regs.low_end      <= pwdata;
        tws_pkg::IDX_SLEW_LEN:     regs.slew_len     <= pwdata;
        tws_pkg::IDX_SLOPE:        regs.slope        <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tws_pkg::IDX_LEVEL_HIGH:   prdata = tws_pkg::DATA_W'(regs.level_high);
      tws_pkg::IDX_LEVEL_LOW:    prdata = tws_pkg::DATA_W'(regs.level_low);
      tws_pkg::IDX_PHASE_OFFSET: prdata = regs.phase_offset;
      tws_pkg::IDX_LOW_END:      prdata = regs.low_end;
      tws_pkg::IDX_SLEW_LEN:     prdata = regs.slew_len;
      tws_pkg::IDX_SLOPE:        prdata = regs.slope;
      default:                   prdata = '0;
    endcase
  end

endmodule

// ----- src/tws_front.sv -----
`include "trapezoid_wave_source_core_defines.svh"

module tws_front #(
  parameter int PHASE_BITS = tws_pkg::PHASE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [tws_pkg::PHASE_W-1:0] time_phase,
  input  tws_pkg::cfg_t                cfg,
  output logic                         out_valid,
  output logic [tws_pkg::PROD_W-1:0]  out_prod,
  output tws_pkg::side_t               out_side
);

  localparam int SUM_W = tws_pkg::PHASE_W + 1;
  localparam int CW    = (PHASE_BITS > SUM_W) ? PHASE_BITS : SUM_W;

  logic                         v0;
  logic                         v1;
  logic                         v2;
  logic [PHASE_BITS-1:0]        p;
  logic [PHASE_BITS-1:0]        p_next;
  logic [tws_pkg::PHASE_W-1:0] n;
  logic [tws_pkg::PHASE_W-1:0] n_next;
  logic [tws_pkg::QUOT_W-1:0]  mag;
  logic [tws_pkg::QUOT_W-1:0]  mag_next;
  tws_pkg::side_t               side1;
  tws_pkg::side_t               side_next;
  tws_pkg::side_t               side2;
  logic [tws_pkg::PROD_W-1:0]  prod;
  logic [tws_pkg::PROD_W-1:0]  prod_next;

  logic [SUM_W-1:0]             sum;
  logic [CW-1:0]                sum_w;
  logic [CW-1:0]                pc;
  logic [CW-1:0]                sl;
  logic [CW-1:0]                le;
  logic [CW-1:0]                re;
  logic [CW-1:0]                pd;
  logic signed [tws_pkg::LEVEL_W:0] dd;
  logic signed [tws_pkg::LEVEL_W:0] dd_abs;
  logic                         slope_min;

  always_comb begin
    sum    = {1'b0, time_phase} + {1'b0, cfg.phase_offset};
    sum_w  = CW'(sum);
    p_next = sum_w[PHASE_BITS-1:0];
  end

  always_comb begin
    pc        = CW'(p);
    sl        = CW'(cfg.slew_len);
    le        = CW'(cfg.low_end);
    re        = le + sl;
    pd        = pc - le;
    dd        = (tws_pkg::LEVEL_W + 1)'(cfg.level_high) - (tws_pkg::LEVEL_W + 1)'(cfg.level_low);
    dd_abs    = dd[tws_pkg::LEVEL_W] ? -dd : dd;
    slope_min = (cfg.slope == tws_pkg::SLOPE_MIN);
    n_next    = '0;
    mag_next  = '0;
    side_next.region = tws_pkg::RGN_HIGH;
    side_next.base   = cfg.level_high;
    side_next.neg    = 1'b0;
    side_next.deriv  = '0;
    if (pc < sl) begin
      side_next.region = tws_pkg::RGN_FALL;
      side_next.base   = cfg.level_high;
      side_next.neg    = (dd > 0);
      side_next.deriv  = slope_min ? tws_pkg::DERIV_MAX : -cfg.slope;
      n_next           = pc[tws_pkg::PHASE_W-1:0];
      mag_next         = dd_abs[tws_pkg::QUOT_W-1:0];
    end else if (pc < le) begin
      side_next.region = tws_pkg::RGN_LOW;
      side_next.base   = cfg.level_low;
    end else if (pc < re) begin
      side_next.region = tws_pkg::RGN_RISE;
      side_next.base   = cfg.level_low;
      side_next.neg    = (dd < 0);
      side_next.deriv  = slope_min ? -tws_pkg::DERIV_MAX : cfg.slope;
      n_next           = pd[tws_pkg::PHASE_W-1:0];
      mag_next         = dd_abs[tws_pkg::QUOT_W-1:0];
    end
  end

  assign prod_next = tws_pkg::PROD_W'(mag) * tws_pkg::PROD_W'(n);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p     <= p_next;
      n     <= n_next;
      mag   <= mag_next;
      side1 <= side_next;
      prod  <= prod_next;
      side2 <= side1;
    end
  end

  assign out_valid = v2;
  assign out_prod  = prod;
  assign out_side  = side2;

  `TWS_CHECK_NOW(a_flat_no_product, v2 && (side2.region == tws_pkg::RGN_LOW || side2.region == tws_pkg::RGN_HIGH), prod == '0)

endmodule

// ----- src/tws_div.sv -----
module tws_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [tws_pkg::PROD_W-1:0]  in_prod,
  input  tws_pkg::side_t               in_side,
  input  logic [tws_pkg::PHASE_W-1:0] slew_len,
  output logic                         out_valid,
  output logic [tws_pkg::QUOT_W-1:0]  out_quot,
  output tws_pkg::side_t               out_side
);

  localparam int N  = tws_pkg::QUOT_W;
  localparam int DW = tws_pkg::PHASE_W;

  logic [N-1:0]   v;
  logic [DW-1:0]  rem [N];
  logic [N-1:0]   low [N];
  tws_pkg::side_t side [N];

  logic [DW-1:0]  r_in [N];
  logic [N-1:0]   l_in [N];
  tws_pkg::side_t s_in [N];
  logic [DW+1:0]  trial [N];
  logic [DW-1:0]  rem_next [N];
  logic [N-1:0]   low_next [N];

  always_comb begin
    r_in[0] = in_prod[tws_pkg::PROD_W-1:N];
    l_in[0] = in_prod[N-1:0];
    s_in[0] = in_side;
    for (int i = 1; i < N; i++) begin
      r_in[i] = rem[i-1];
      l_in[i] = low[i-1];
      s_in[i] = side[i-1];
    end
    for (int i = 0; i < N; i++) begin
      trial[i] = {1'b0, r_in[i], l_in[i][N-1]} - {2'b00, slew_len};
      if (trial[i][DW+1]) begin
        rem_next[i] = {r_in[i][DW-2:0], l_in[i][N-1]};
      end else begin
        rem_next[i] = trial[i][DW-1:0];
      end
      low_next[i] = {l_in[i][N-2:0], ~trial[i][DW+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        rem[i]  <= rem_next[i];
        low[i]  <= low_next[i];
        side[i] <= s_in[i];
      end
    end
  end

  assign out_valid = v[N-1];
  assign out_quot  = low[N-1];
  assign out_side  = side[N-1];

endmodule

// ----- src/tws_out.sv -----
`include "trapezoid_wave_source_core_defines.svh"

module tws_out #(
  parameter int LEVEL_BITS = tws_pkg::LEVEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [tws_pkg::QUOT_W-1:0]         in_quot,
  input  tws_pkg::side_t                      in_side,
  output logic                                en,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [LEVEL_BITS-1:0]        voltage,
  output logic signed [tws_pkg::DERIV_W-1:0] derivative,
  output tws_pkg::region_t                    region
);

  localparam int SW = tws_pkg::LEVEL_W + 2;
  localparam int VW = (LEVEL_BITS > SW) ? LEVEL_BITS : SW;
  localparam logic signed [VW-1:0] VMAX = VW'((64'sd1 <<< (LEVEL_BITS - 1)) - 64'sd1);
  localparam logic signed [VW-1:0] VMIN = ~VMAX;

  logic                                o_valid;
  logic signed [LEVEL_BITS-1:0]        o_voltage;
  logic signed [tws_pkg::DERIV_W-1:0] o_deriv;
  tws_pkg::region_t                    o_region;
  logic                                s_valid;
  logic signed [LEVEL_BITS-1:0]        s_voltage;
  logic signed [tws_pkg::DERIV_W-1:0] s_deriv;
  tws_pkg::region_t                    s_region;

  logic                                ramp;
  logic signed [SW-1:0]                qs;
  logic signed [SW-1:0]                vsum;
  logic signed [VW-1:0]                vext;
  logic signed [VW-1:0]                vclamp;
  logic signed [LEVEL_BITS-1:0]        voltage_next;
  logic                                push;
  logic                                take;

  always_comb begin
    ramp = (in_side.region == tws_pkg::RGN_FALL) || (in_side.region == tws_pkg::RGN_RISE);
    qs   = '0;
    if (ramp) begin
      qs = in_side.neg ? -$signed({2'b00, in_quot}) : $signed({2'b00, in_quot});
    end
    vsum = SW'(in_side.base) + qs;
    vext = VW'(vsum);
    if (vext > VMAX) begin
      vclamp = VMAX;
    end else if (vext < VMIN) begin
      vclamp = VMIN;
    end else begin
      vclamp = vext;
    end
    voltage_next = vclamp[LEVEL_BITS-1:0];
  end

  assign en   = !s_valid;
  assign push = in_valid && en;
  assign take = o_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (!o_valid || take) begin
      o_valid <= s_valid || push;
      s_valid <= 1'b0;
    end else if (push) begin
      s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || take) begin
      if (s_valid) begin
        o_voltage <= s_voltage;
        o_deriv   <= s_deriv;
        o_region  <= s_region;
      end else begin
        o_voltage <= voltage_next;
        o_deriv   <= in_side.deriv;
        o_region  <= in_side.region;
      end
    end else if (push) begin
      s_voltage <= voltage_next;
      s_deriv   <= in_side.deriv;
      s_region  <= in_side.region;
    end
  end

  assign out_valid  = o_valid;
  assign voltage    = o_voltage;
  assign derivative = o_deriv;
  assign region     = o_region;

  `TWS_CHECK_NOW(a_skid_behind_out, s_valid, o_valid)
  `TWS_CHECK_NOW(a_out_from_pipe, $rose(o_valid), $past(push))
  `TWS_CHECK_NEXT(a_skid_hold, s_valid && !take, s_valid)

endmodule

// ----- dv/tb_trapezoid_wave_source_core.sv -----
`timescale 1ns / 1ps

module tb_trapezoid_wave_source_core;

  localparam logic [2:0] IDX_SPARE_A = 3'd6;
  localparam logic [2:0] IDX_SPARE_B = 3'd7;
  localparam int         MAX_WAIT    = 13;
  localparam int         TAIL_CYCLES = 40;
  localparam int         RAND_PHASES = 15;
  localparam int         PHASE_ITEMS = 92;

  typedef struct packed {
    logic signed [tws_pkg::LEVEL_W-1:0] voltage;
    logic signed [tws_pkg::DERIV_W-1:0] derivative;
    tws_pkg::region_t                   region;
  } wave_sample_t;

  class wave_scoreboard;
    tws_pkg::cfg_t  cfg;
    wave_sample_t   pending_q[$];
    int unsigned    n_phase;
    int unsigned    n_wave;
    int unsigned    n_bad;
    int unsigned    n_writes;
    int unsigned    region_hits[4];

    function new();
      cfg.level_high   = tws_pkg::LEVEL_HIGH_RST;
      cfg.level_low    = tws_pkg::LEVEL_LOW_RST;
      cfg.phase_offset = tws_pkg::PHASE_OFFSET_RST;
      cfg.low_end      = tws_pkg::LOW_END_RST;
      cfg.slew_len     = tws_pkg::SLEW_LEN_RST;
      cfg.slope        = tws_pkg::SLOPE_RST;
    endfunction

    function void update_reg(logic [2:0] idx, logic [tws_pkg::DATA_W-1:0] val);
      n_writes++;
      case (idx)
        tws_pkg::IDX_LEVEL_HIGH:   cfg.level_high   = val[tws_pkg::LEVEL_W-1:0];
        tws_pkg::IDX_LEVEL_LOW:    cfg.level_low    = val[tws_pkg::LEVEL_W-1:0];
        tws_pkg::IDX_PHASE_OFFSET: cfg.phase_offset = val;
        tws_pkg::IDX_LOW_END:      cfg.low_end      = val;
        tws_pkg::IDX_SLEW_LEN:     cfg.slew_len     = val;
        tws_pkg::IDX_SLOPE:        cfg.slope        = val;
        default: ;
      endcase
    endfunction

    function longint interpolate(longint from, longint to, longint n);
      longint span;
      span = to - from;
      return from + (span * n) / longint'(cfg.slew_len);
    endfunction

    function wave_sample_t compute_wave(logic [tws_pkg::PHASE_W-1:0] time_phase);
      wave_sample_t                s;
      logic [tws_pkg::PHASE_W-1:0] p;
      logic [tws_pkg::PHASE_W:0]   rise_end;
      longint                      hi;
      longint                      lo;
      longint                      v;
      longint                      d;
      hi       = longint'($signed(cfg.level_high));
      lo       = longint'($signed(cfg.level_low));
      p        = time_phase + cfg.phase_offset;
      rise_end = {1'b0, cfg.low_end} + {1'b0, cfg.slew_len};
      if (p < cfg.slew_len) begin
        s.region = tws_pkg::RGN_FALL;
        d = -longint'($signed(cfg.slope));
        v = interpolate(hi, lo, longint'(p));
      end else if (p < cfg.low_end) begin
        s.region = tws_pkg::RGN_LOW;
        d = 0;
        v = lo;
      end else if ({1'b0, p} < rise_end) begin
        s.region = tws_pkg::RGN_RISE;
        d = longint'($signed(cfg.slope));
        v = interpolate(lo, hi, longint'(p - cfg.low_end));
      end else begin
        s.region = tws_pkg::RGN_HIGH;
        d = 0;
        v = hi;
      end
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      if (d < -64'sd2147483647) d = -64'sd2147483647;
      s.voltage    = v[tws_pkg::LEVEL_W-1:0];
      s.derivative = d[tws_pkg::DERIV_W-1:0];
      return s;
    endfunction

    function void note_phase(logic [tws_pkg::PHASE_W-1:0] time_phase);
      n_phase++;
      pending_q.push_back(compute_wave(time_phase));
    endfunction

    function void check_wave(logic signed [tws_pkg::LEVEL_W-1:0] v,
                             logic signed [tws_pkg::DERIV_W-1:0] d,
                             logic [1:0] r);
      wave_sample_t exp_s;
      n_wave++;
      if (pending_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("[%0t] unexpected sample v=%0d d=%0d r=%0d", $realtime, v, d, r);
        return;
      end
      exp_s = pending_q.pop_front();
      region_hits[exp_s.region]++;
      if (exp_s.voltage !== v || exp_s.derivative !== d || exp_s.region !== r) begin
        n_bad++;
        if (n_bad <= 10)
          $display("[%0t] sample %0d: expected v=%0d d=%0d r=%0d, got v=%0d d=%0d r=%0d",
                   $realtime, n_wave, exp_s.voltage, exp_s.derivative, exp_s.region,
                   v, d, r);
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [tws_pkg::ADDR_W-1:0]   paddr;
  logic [tws_pkg::DATA_W-1:0]   pwdata;
  logic [tws_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  bit                           src_idle;
  bit                           sink_idle;
  wave_scoreboard               sb;

  tws_phase_if phase_if ();
  tws_wave_if #(.LEVEL_BITS(tws_pkg::LEVEL_W)) wave_if ();

  trapezoid_wave_source_core DUT (
    .clk          (clk),
    .rst          (rst),
    .phase_stream (phase_if),
    .wave_stream  (wave_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (wave_if.valid && wave_if.ready)
        sb.check_wave(wave_if.voltage, wave_if.derivative, wave_if.region);
      if (phase_if.valid && phase_if.ready)
        sb.note_phase(phase_if.time_phase);
    end
  end

  initial begin
    int unsigned stall;
    wave_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = sink_idle ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall != 0) begin
        wave_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      wave_if.ready = 1'b1;
      @(posedge clk);
      while (!wave_if.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic set_reg(input logic [2:0] idx, input logic [tws_pkg::DATA_W-1:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.update_reg(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic send_phase(input logic [tws_pkg::PHASE_W-1:0] tp);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, MAX_WAIT) : 0;
    @(negedge clk);
    if (gap != 0) begin
      phase_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    phase_if.valid      = 1'b1;
    phase_if.time_phase = tp;
    @(posedge clk);
    while (!phase_if.ready) @(posedge clk);
  endtask

  // p is the wrapped phase seen by the block; undo the offset
  task automatic send_at(input logic [tws_pkg::PHASE_W-1:0] p);
    send_phase(p - sb.cfg.phase_offset);
  endtask

  task automatic drain();
    @(negedge clk);
    phase_if.valid      = 1'b0;
    phase_if.time_phase = $urandom();
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic probe_edges();
    logic [tws_pkg::PHASE_W-1:0] le;
    logic [tws_pkg::PHASE_W-1:0] sl;
    le = sb.cfg.low_end;
    sl = sb.cfg.slew_len;
    send_at('0);
    send_at(sl - 1);
    send_at(sl);
    send_at(le - 1);
    send_at(le);
    send_at(le + sl - 1);
    send_at(le + sl);
    send_at('1);
  endtask

  function automatic logic [tws_pkg::PHASE_W-1:0] pick_phase_point();
    logic [tws_pkg::PHASE_W-1:0] b;
    logic [tws_pkg::PHASE_W-1:0] sl;
    sl = sb.cfg.slew_len;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3: b = '0;
      4: b = sl;
      5: b = sb.cfg.low_end;
      6: b = sb.cfg.low_end + sl;
      7: return (sl == 0) ? $urandom() : $urandom() % sl;
      8: return (sl == 0) ? $urandom() : sb.cfg.low_end + $urandom() % sl;
      default: b = '1;
    endcase
    return b + tws_pkg::PHASE_W'($urandom_range(0, 6)) - tws_pkg::PHASE_W'(3);
  endfunction

  function automatic logic [tws_pkg::LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_config();
    logic [tws_pkg::PHASE_W-1:0] sl;
    case ($urandom_range(0, 7))
      0: sl = '0;
      1: sl = 32'd1;
      2: sl = $urandom_range(1, 64);
      3: sl = '1;
      4, 5: sl = $urandom() >> $urandom_range(0, 31);
      default: sl = $urandom();
    endcase
    set_reg(tws_pkg::IDX_LEVEL_HIGH, {16'($urandom()), pick_level()});
    set_reg(tws_pkg::IDX_LEVEL_LOW, {16'($urandom()), pick_level()});
    case ($urandom_range(0, 3))
      0: set_reg(tws_pkg::IDX_PHASE_OFFSET, '0);
      1: set_reg(tws_pkg::IDX_PHASE_OFFSET, '1);
      default: set_reg(tws_pkg::IDX_PHASE_OFFSET, $urandom());
    endcase
    set_reg(tws_pkg::IDX_SLEW_LEN, sl);
    case ($urandom_range(0, 6))
      0: set_reg(tws_pkg::IDX_LOW_END, '0);
      1: set_reg(tws_pkg::IDX_LOW_END, '1);
      2: set_reg(tws_pkg::IDX_LOW_END, sl);
      3: set_reg(tws_pkg::IDX_LOW_END, sl - 1);
      default: set_reg(tws_pkg::IDX_LOW_END, $urandom());
    endcase
    case ($urandom_range(0, 5))
      0: set_reg(tws_pkg::IDX_SLOPE, tws_pkg::SLOPE_MIN);
      1: set_reg(tws_pkg::IDX_SLOPE, tws_pkg::DERIV_MAX);
      2: set_reg(tws_pkg::IDX_SLOPE, '0);
      default: set_reg(tws_pkg::IDX_SLOPE, $urandom());
    endcase
    if ($urandom_range(0, 3) == 0)
      set_reg($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, $urandom());
  endtask

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    sb                  = new();
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    phase_if.valid      = 1'b0;
    phase_if.time_phase = '0;
    src_idle            = 1'b0;
    sink_idle           = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings, every boundary
    probe_edges();
    drain();

    // extremes: full-scale levels, most negative slope, offset wraps
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    set_reg(tws_pkg::IDX_LEVEL_HIGH, 32'h0000_7FFF);
    set_reg(tws_pkg::IDX_LEVEL_LOW, 32'hFFFF_8000);
    set_reg(tws_pkg::IDX_PHASE_OFFSET, 32'hFFFF_FFFF);
    set_reg(tws_pkg::IDX_LOW_END, 32'h8000_0000);
    set_reg(tws_pkg::IDX_SLEW_LEN, 32'h4000_0000);
    set_reg(tws_pkg::IDX_SLOPE, tws_pkg::SLOPE_MIN);
    send_at(32'h1555_5555);
    send_at(32'h9555_5555);
    send_phase(32'd0);
    send_phase(32'd1);
    drain();

    // zero slew: hard steps
    set_reg(tws_pkg::IDX_SLEW_LEN, 32'd0);
    set_reg(tws_pkg::IDX_SLOPE, tws_pkg::DERIV_MAX);
    send_at(32'd0);
    send_at(32'h7FFF_FFFF);
    send_at(32'h8000_0000);
    drain();

    // rising ramp runs past the period end
    set_reg(tws_pkg::IDX_LOW_END, 32'hF000_0000);
    set_reg(tws_pkg::IDX_SLEW_LEN, 32'h2000_0000);
    send_at(32'hFFFF_FFFF);
    send_at(32'hF000_0000);
    send_at(32'h1000_0000);
    drain();

    // low plateau swallowed by the falling ramp
    set_reg(tws_pkg::IDX_LOW_END, 32'h1000_0000);
    send_at(32'h0FFF_FFFF);
    send_at(32'h1FFF_FFFF);
    send_at(32'h2000_0000);
    send_at(32'h3000_0000);
    drain();

    // spare addresses must not disturb anything
    set_reg(IDX_SPARE_A, 32'hFFFF_FFFF);
    set_reg(IDX_SPARE_B, 32'h0000_0000);
    send_at(32'h1800_0000);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_config();
      src_idle  = $urandom_range(0, 2) != 0;
      sink_idle = $urandom_range(0, 2) != 0;
      probe_edges();
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_at(pick_phase_point());
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Run: %0d transfers in, %0d out, %0d register writes, %0d mismatches",
             sb.n_phase, sb.n_wave, sb.n_writes, sb.n_bad);
    $display("Regions seen: falling %0d, low %0d, rising %0d, high %0d",
             sb.region_hits[tws_pkg::RGN_FALL], sb.region_hits[tws_pkg::RGN_LOW],
             sb.region_hits[tws_pkg::RGN_RISE], sb.region_hits[tws_pkg::RGN_HIGH]);
    if (sb.n_bad == 0 && sb.pending_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/tws_pkg.sv
src/tws_stream_if.sv
src/tws_regs.sv
src/tws_front.sv
src/tws_div.sv
src/tws_out.sv
src/trapezoid_wave_source_core.sv
dv/tb_trapezoid_wave_source_core.sv
